[hdl/cal_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the calendar date counter.
// No dependencies; every other file of the block refers to it by scoped names.
package cal_pkg;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned DayW     = 5;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned YearW    = 14;
  localparam int unsigned WdW      = 3;
  localparam int unsigned LenW     = 5;
  localparam int unsigned OrderW   = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned Mod100W  = 7;
  localparam int unsigned Mod400W  = 9;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  // floor(y / 100) == (y * Recip100) >> Recip100Shift for every 14-bit y.
  localparam int unsigned Recip100W     = 13;
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned Prod100W      = YearW + Recip100W;
  // floor(s / 7) == (s * Recip7) >> Recip7Shift for every 15-bit s.
  localparam int unsigned SumW          = 15;
  localparam int unsigned Recip7W       = 16;
  localparam int unsigned Recip7        = 37450;
  localparam int unsigned Recip7Shift   = 18;
  localparam int unsigned Prod7W        = SumW + Recip7W;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_COMPARE = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  typedef enum logic [OrderW-1:0] {
    ORDER_EQUAL   = 2'd0,
    ORDER_LATER   = 2'd1,
    ORDER_EARLIER = 2'd2
  } order_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  // A classified command as it waits between the front and the back end.
  typedef struct packed {
    func_e                func;
    logic [DayW-1:0]      day;
    logic [MonthW-1:0]    month;
    logic [YearW-1:0]     year;
    logic                 load_ok;
    logic [Mod100W-1:0]   yr_mod100;
    logic [Mod400W-1:0]   yr_mod400;
    logic [WdW-1:0]       weekday;
  } cmd_t;

  // Month term of the weekday sum; months outside 1..12 give 0.
  function automatic logic [WdW-1:0] month_offset(input logic [MonthW-1:0] m);
    logic [WdW-1:0] off;
    unique case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // Days in a month; months outside 1..12 give 0.
  function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [LenW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[hdl/calendar_date_counter.sv]
`timescale 1ns / 1ps
// Top level of the Gregorian calendar date counter with weekday.
// Instantiates cal_front, cal_queue and cal_back; uses cal_pkg.
//
// The block keeps one Gregorian date, reset to Monday 1 January of year 1,
// and answers every input beat with exactly one output beat. The input tuser
// selects the operation (load, advance one day, compare, read) and tdata
// carries the date used by load and compare. A load that names a month
// outside 1 to 12, a day outside the month, or a year outside 1 to MAX_YEAR
// is rejected and the stored date is kept. Advancing from 31 December of
// MAX_YEAR holds the date and reports overflow. Each output beat gives the
// stored date after the operation, its weekday (0 is Sunday), the length of
// the stored month, the compare order (zero outside compare) and a status.
// The block sustains one beat per clock cycle in both directions while the
// output is not stalled. Three front stages compute the load check and
// the weekday of the candidate date with three reciprocal multipliers,
// then a beat passes through the two-entry command queue and the
// registered output. The back end tracks the weekday and the year
// residues modulo 100 and 400 incrementally, so an advance costs no division.
module calendar_date_counter #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0 up: day_in[4:0], month_in[8:5], year_in[22:9], zero pad.
  input  logic [cal_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0 up: func[1:0].
  input  logic [cal_pkg::FuncW-1:0]    s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0 up: day_out[4:0], month_out[8:5], year_out[22:9],
  // weekday[25:23], month_length[30:26], order[32:31], status[34:33], zero pad.
  output logic [cal_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic          push, pop, full, empty;
  cal_pkg::cmd_t front_cmd, back_cmd;

  cal_front #(
    .MAX_YEAR(MAX_YEAR)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .func_i  (cal_pkg::func_e'(s_axis_tuser_i)),
    .day_i   (s_axis_tdata_i[4:0]),
    .month_i (s_axis_tdata_i[8:5]),
    .year_i  (s_axis_tdata_i[22:9]),
    .push_o  (push),
    .cmd_o   (front_cmd),
    .full_i  (full)
  );

  cal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (back_cmd),
    .empty_o (empty)
  );

  cal_back #(
    .MAX_YEAR(MAX_YEAR)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (back_cmd),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

endmodule

[hdl/cal_front.sv]
`timescale 1ns / 1ps
// Front end: takes input beats, checks loads and precomputes the weekday
// and the year residues of a candidate date over three stages. Uses cal_pkg.
module cal_front #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  cal_pkg::func_e             func_i,
  input  logic [cal_pkg::DayW-1:0]   day_i,
  input  logic [cal_pkg::MonthW-1:0] month_i,
  input  logic [cal_pkg::YearW-1:0]  year_i,
  output logic                       push_o,
  output cal_pkg::cmd_t              cmd_o,
  input  logic                       full_i
);

  // Pipeline advances as a whole unless the last stage is blocked.
  logic en;
  logic s3_valid_q;
  assign en      = !(s3_valid_q && full_i);
  assign ready_o = en;
  assign push_o  = s3_valid_q && !full_i;

  // Stage 1: adjusted year and the two reciprocal products.
  logic [cal_pkg::YearW-1:0]    adj;
  logic                         s1_valid_q;
  cal_pkg::func_e               s1_func_q;
  logic [cal_pkg::DayW-1:0]     s1_day_q;
  logic [cal_pkg::MonthW-1:0]   s1_month_q;
  logic [cal_pkg::YearW-1:0]    s1_year_q, s1_adj_q;
  logic [cal_pkg::Prod100W-1:0] s1_py_q, s1_pa_q;

  assign adj = (month_i < 4'd3 && year_i != '0) ? year_i - 14'd1 : year_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_func_q  <= func_i;
      s1_day_q   <= day_i;
      s1_month_q <= month_i;
      s1_year_q  <= year_i;
      s1_adj_q   <= adj;
      s1_py_q    <= cal_pkg::Prod100W'(year_i) * cal_pkg::Prod100W'(cal_pkg::Recip100);
      s1_pa_q    <= cal_pkg::Prod100W'(adj) * cal_pkg::Prod100W'(cal_pkg::Recip100);
    end
  end

  // Stage 2: quotients, residues, validity and the weekday sum.
  logic [7:0]                  q100, qa100;
  logic [5:0]                  q400, qa400;
  logic [cal_pkg::Mod100W-1:0] r100;
  logic [cal_pkg::Mod400W-1:0] r400;
  logic                        leap;
  logic [cal_pkg::LenW-1:0]    len;
  logic                        load_ok;
  logic [15:0]                 sum_w;

  assign q100  = s1_py_q[cal_pkg::Prod100W-1:cal_pkg::Recip100Shift];
  assign q400  = q100[7:2];
  assign qa100 = s1_pa_q[cal_pkg::Prod100W-1:cal_pkg::Recip100Shift];
  assign qa400 = qa100[7:2];
  assign r100  = cal_pkg::Mod100W'(s1_year_q - 14'(q100) * 14'd100);
  assign r400  = cal_pkg::Mod400W'(s1_year_q - 14'(q400) * 14'd400);
  assign leap  = (s1_year_q[1:0] == 2'd0 && r100 != '0) || r400 == '0;
  assign len   = cal_pkg::month_len(s1_month_q, leap);
  assign load_ok = s1_month_q >= 4'd1 && s1_month_q <= 4'd12
                && s1_day_q >= 5'd1 && s1_day_q <= len
                && s1_year_q >= 14'd1 && s1_year_q <= cal_pkg::YearW'(MAX_YEAR);
  assign sum_w = 16'(s1_adj_q) + 16'(s1_adj_q >> 2) - 16'(qa100) + 16'(qa400)
               + 16'(cal_pkg::month_offset(s1_month_q)) + 16'(s1_day_q);

  logic                        s2_valid_q;
  cal_pkg::cmd_t               s2_cmd_q;
  logic [cal_pkg::SumW-1:0]    s2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cmd_q.func      <= s1_func_q;
      s2_cmd_q.day       <= s1_day_q;
      s2_cmd_q.month     <= s1_month_q;
      s2_cmd_q.year      <= s1_year_q;
      s2_cmd_q.load_ok   <= load_ok;
      s2_cmd_q.yr_mod100 <= r100;
      s2_cmd_q.yr_mod400 <= r400;
      s2_cmd_q.weekday   <= '0;
      s2_sum_q           <= cal_pkg::SumW'(sum_w);
    end
  end

  // Stage 3: reciprocal product for the remainder by seven.
  cal_pkg::cmd_t              s3_cmd_q;
  logic [cal_pkg::SumW-1:0]   s3_sum_q;
  logic [cal_pkg::Prod7W-1:0] s3_p7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_cmd_q <= s2_cmd_q;
      s3_sum_q <= s2_sum_q;
      s3_p7_q  <= cal_pkg::Prod7W'(s2_sum_q) * cal_pkg::Prod7W'(cal_pkg::Recip7);
    end
  end

  logic [12:0] q7;
  assign q7 = s3_p7_q[cal_pkg::Prod7W-1:cal_pkg::Recip7Shift];

  always_comb begin
    cmd_o         = s3_cmd_q;
    cmd_o.weekday = cal_pkg::WdW'(s3_sum_q - cal_pkg::SumW'(q7) * 15'd7);
  end

endmodule

[hdl/cal_queue.sv]
`timescale 1ns / 1ps
// Two-entry command queue between the front and the back end.
// Uses cal_pkg for the command type.
module cal_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cal_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output cal_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  cal_pkg::cmd_t entries_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hdl/cal_back.sv]
`timescale 1ns / 1ps
// Back end: holds the date, its year residues and weekday, executes one
// command per cycle unless stalled, registers the result. Uses cal_pkg.
module cal_back #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  cal_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [cal_pkg::OutDataW-1:0] data_o
);

  logic [cal_pkg::DayW-1:0]    day_q, day_d;
  logic [cal_pkg::MonthW-1:0]  month_q, month_d;
  logic [cal_pkg::YearW-1:0]   year_q, year_d;
  logic [cal_pkg::Mod100W-1:0] mod100_q, mod100_d;
  logic [cal_pkg::Mod400W-1:0] mod400_q, mod400_d;
  logic [cal_pkg::WdW-1:0]     wd_q, wd_d, wd_next;
  logic                        out_valid_q;
  logic [cal_pkg::OutDataW-1:0] out_data_q;
  logic                        leap_cur, leap_d;
  logic [cal_pkg::LenW-1:0]    len_cur, len_d;
  cal_pkg::order_e             order;
  cal_pkg::status_e            status;

  assign pop_o   = !empty_i && (!out_valid_q || ready_i);
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  assign leap_cur = (year_q[1:0] == 2'd0 && mod100_q != '0) || mod400_q == '0;
  assign len_cur  = cal_pkg::month_len(month_q, leap_cur);
  assign wd_next  = (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;

  always_comb begin
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    wd_d     = wd_q;
    order    = cal_pkg::ORDER_EQUAL;
    status   = cal_pkg::STATUS_OK;
    unique case (cmd_i.func)
      cal_pkg::FUNC_LOAD: begin
        if (cmd_i.load_ok) begin
          day_d    = cmd_i.day;
          month_d  = cmd_i.month;
          year_d   = cmd_i.year;
          mod100_d = cmd_i.yr_mod100;
          mod400_d = cmd_i.yr_mod400;
          wd_d     = cmd_i.weekday;
        end else begin
          status = cal_pkg::STATUS_REJECTED;
        end
      end
      cal_pkg::FUNC_ADVANCE: begin
        priority if (day_q < len_cur) begin
          day_d = day_q + 5'd1;
          wd_d  = wd_next;
        end else if (month_q < 4'd12) begin
          day_d   = 5'd1;
          month_d = month_q + 4'd1;
          wd_d    = wd_next;
        end else if (year_q < cal_pkg::YearW'(MAX_YEAR)) begin
          day_d    = 5'd1;
          month_d  = 4'd1;
          year_d   = year_q + 14'd1;
          mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
          mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
          wd_d     = wd_next;
        end else begin
          status = cal_pkg::STATUS_OVERFLOW;
        end
      end
      cal_pkg::FUNC_COMPARE: begin
        priority if (year_q != cmd_i.year) begin
          order = (year_q > cmd_i.year) ? cal_pkg::ORDER_LATER : cal_pkg::ORDER_EARLIER;
        end else if (month_q != cmd_i.month) begin
          order = (month_q > cmd_i.month) ? cal_pkg::ORDER_LATER : cal_pkg::ORDER_EARLIER;
        end else if (day_q != cmd_i.day) begin
          order = (day_q > cmd_i.day) ? cal_pkg::ORDER_LATER : cal_pkg::ORDER_EARLIER;
        end else begin
          order = cal_pkg::ORDER_EQUAL;
        end
      end
      cal_pkg::FUNC_READ: begin
        order = cal_pkg::ORDER_EQUAL;
      end
      default: begin
        order = cal_pkg::ORDER_EQUAL;
      end
    endcase
  end

  assign leap_d = (year_d[1:0] == 2'd0 && mod100_d != '0) || mod400_d == '0;
  assign len_d  = cal_pkg::month_len(month_d, leap_d);

  // Reset date is Monday 1 January of year 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q       <= 5'd1;
      month_q     <= 4'd1;
      year_q      <= 14'd1;
      mod100_q    <= 7'd1;
      mod400_q    <= 9'd1;
      wd_q        <= 3'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        day_q       <= day_d;
        month_q     <= month_d;
        year_q      <= year_d;
        mod100_q    <= mod100_d;
        mod400_q    <= mod400_d;
        wd_q        <= wd_d;
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= {5'd0, status, order, len_d, wd_d, year_d, month_d, day_d};
    end
  end

endmodule

[hdl/cal_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the calendar date counter, bound to the top level.
// Uses cal_pkg for widths and codes.
module cal_checker #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [cal_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic [cal_pkg::FuncW-1:0]    s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [cal_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // A stalled result beat stays and keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // The stored day always lies within the reported month length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[4:0] >= 5'd1
                     && m_axis_tdata_o[4:0] <= m_axis_tdata_o[30:26])
    else $error("day outside month length");

  // February is 28 or 29 days long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[8:5] == 4'd2
      |-> m_axis_tdata_o[30:26] == 5'd28 || m_axis_tdata_o[30:26] == 5'd29)
    else $error("bad February length");

  // Overflow is reported only when the last representable day is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34:33] == cal_pkg::STATUS_OVERFLOW
      |-> m_axis_tdata_o[4:0] == 5'd31 && m_axis_tdata_o[8:5] == 4'd12
       && m_axis_tdata_o[22:9] == cal_pkg::YearW'(MAX_YEAR))
    else $error("overflow away from the last day");

  // A compare order and a non-ok status never come together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32:31] != cal_pkg::ORDER_EQUAL
      |-> m_axis_tdata_o[34:33] == cal_pkg::STATUS_OK)
    else $error("order with non-ok status");

endmodule

bind calendar_date_counter cal_checker #(.MAX_YEAR(MAX_YEAR)) u_cal_checker (.*);
